// ===== design/sra_pkg.sv =====
// Shared types and constants for the segment range allocator.
`timescale 1ns / 1ps
package sra_pkg;

  // Field widths of an item and of a free table entry.
  localparam int BASE_W = 10;
  localparam int LEN_W  = 11;
  localparam int END_W  = 12;

  // Request kinds carried in the func field.
  localparam logic FUNC_CREATE = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Byte address of the memory size register.
  localparam logic [2:0] ADDR_MEMORY_WORDS = 3'd0;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADLEN  = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_INUSE   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // Commands broadcast to the row of free table cells.
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_INIT,
    OP_INS,
    OP_DEL,
    OP_SPLIT2,
    OP_PRE,
    OP_POST,
    OP_GROW_L,
    OP_GROW_R,
    OP_MERGE3
  } op_t;

  // One free range.
  typedef struct packed {
    logic              used;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Command with the range it refers to.
  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // What a cell reports about its range against the broadcast range.
  typedef struct packed {
    logic hit;
    logic gt;
    logic touch_l;
    logic touch_r;
    logic has_pre;
    logic has_post;
  } flags_t;

endpackage

// ===== design/sra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sra_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sra_cell.sv =====
// One free table entry with its neighbor handoff and local compares.
`timescale 1ns / 1ps
module sra_cell #(
  parameter int QW  = 4,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sra_pkg::cmd_t    cmd,
  input  logic [QW-1:0]    pos,
  input  sra_pkg::entry_t  left_cur,
  input  sra_pkg::entry_t  left_post,
  input  sra_pkg::entry_t  right_cur,
  output sra_pkg::entry_t  cur,
  output sra_pkg::entry_t  post,
  output sra_pkg::flags_t  flags
);
  import sra_pkg::*;

  entry_t           ent_r;
  entry_t           ent_nxt;
  logic [END_W-1:0] b_end;
  logic [END_W-1:0] c_end;
  logic [END_W-1:0] b_base_x;
  logic [END_W-1:0] c_base_x;
  entry_t           pre;
  logic             is_eq;
  logic             is_gt;
  logic             is_next;
  logic             is_ge;

  assign cur = ent_r;

  // Ends of the broadcast range and of this entry.
  assign b_base_x = END_W'(cmd.base);
  assign c_base_x = END_W'(ent_r.base);
  assign b_end    = b_base_x + END_W'(cmd.len);
  assign c_end    = c_base_x + END_W'(ent_r.len);

  // Local compares against the broadcast range.
  assign flags.hit      = ent_r.used && (c_base_x <= b_base_x) && (c_end >= b_end);
  assign flags.gt       = ent_r.used && (b_base_x < c_base_x);
  assign flags.touch_l  = ent_r.used && (c_end == b_base_x);
  assign flags.touch_r  = ent_r.used && (c_base_x == b_end);
  assign flags.has_pre  = c_base_x < b_base_x;
  assign flags.has_post = c_end > b_end;

  // Pieces left before and after the broadcast range.
  assign pre.used  = 1'b1;
  assign pre.base  = ent_r.base;
  assign pre.len   = LEN_W'(b_base_x - c_base_x);
  assign post.used = 1'b1;
  assign post.base = b_end[BASE_W-1:0];
  assign post.len  = LEN_W'(c_end - b_end);

  // Place of this cell relative to the command position.
  assign is_eq   = (pos == QW'(IDX));
  assign is_gt   = (QW'(IDX) > pos);
  assign is_ge   = is_eq || is_gt;
  assign is_next = ((QW + 1)'(pos) + (QW + 1)'(1)) == (QW + 1)'(IDX);

  // Next entry value.
  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_INIT: begin
        ent_nxt = '0;
        if (IDX == 0) begin
          ent_nxt.used = (cmd.len != '0);
          ent_nxt.len  = cmd.len;
        end
      end
      OP_INS: begin
        if (is_eq) begin
          ent_nxt.used = 1'b1;
          ent_nxt.base = cmd.base;
          ent_nxt.len  = cmd.len;
        end else if (is_gt) begin
          ent_nxt = left_cur;
        end
      end
      OP_DEL: begin
        if (is_ge) begin
          ent_nxt = right_cur;
        end
      end
      OP_SPLIT2: begin
        if (is_eq) begin
          ent_nxt = pre;
        end else if (is_next) begin
          ent_nxt = left_post;
        end else if (is_gt) begin
          ent_nxt = left_cur;
        end
      end
      OP_PRE: begin
        if (is_eq) begin
          ent_nxt = pre;
        end
      end
      OP_POST: begin
        if (is_eq) begin
          ent_nxt = post;
        end
      end
      OP_GROW_L: begin
        if (is_eq) begin
          ent_nxt.len = ent_r.len + cmd.len;
        end
      end
      OP_GROW_R: begin
        if (is_eq) begin
          ent_nxt.base = cmd.base;
          ent_nxt.len  = ent_r.len + cmd.len;
        end
      end
      OP_MERGE3: begin
        if (is_eq) begin
          ent_nxt.len = ent_r.len + cmd.len + right_cur.len;
        end else if (is_gt) begin
          ent_nxt = right_cur;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Entry register; only the used bit needs reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.used <= 1'b0;
    end else begin
      ent_r.used <= ent_nxt.used;
    end
    ent_r.base <= ent_nxt.base;
    ent_r.len  <= ent_nxt.len;
  end

endmodule

// ===== design/segment_range_allocator_core.sv =====
// Top level of the segment range allocator: control, segment store and cell row.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_func, in_seg_id, in_seg_start, in_seg_size
//  out     | output    | out_valid / out_ready  | out_status, out_free_ranges
//  cfg     | input     | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One item at a time. A create scans the free table from the first entry for the
// covering free range (one cell is examined per cycle); a zero length create
// skips the scan. A remove passes through S_RD before its scan for the insertion
// place, since the segment store has a registered read.
// After reset the S_INIT state loads the free table before the first item is taken.
// A new item is taken while the previous result still waits on out_ready.
`timescale 1ns / 1ps
module segment_range_allocator_core #(
  parameter int MEM_WORDS  = 1024,
  parameter int SEG_IDS    = 8,
  parameter int FREE_SLOTS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [2:0]  in_seg_id,
  input  logic [9:0]  in_seg_start,
  input  logic [10:0] in_seg_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_free_ranges,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sra_pkg::*;

  localparam int QW = $clog2(FREE_SLOTS + 1);
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int AW = $clog2(SEG_IDS);
  localparam int RW = BASE_W + LEN_W;
  localparam logic [LEN_W-1:0] MW_RST = (MEM_WORDS > 2047) ? 11'd2047 : LEN_W'(MEM_WORDS);
  localparam logic [QW-1:0] FULL = QW'(FREE_SLOTS);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_SCAN, S_FIN} state_t;

  state_t            state_r;
  logic              func_r;
  logic              id_ok_r;
  logic [AW-1:0]     id_addr_r;
  logic [BASE_W-1:0] bbase_r;
  logic [LEN_W-1:0]  blen_r;
  logic [QW-1:0]     k_r;
  logic [QW-1:0]     n_r;
  logic              prev_tl_r;
  status_t           st_r;
  logic [LEN_W-1:0]  mw_r;
  logic [SEG_IDS-1:0] aused_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [3:0]        out_free_r;

  cmd_t              cmd;
  logic [QW-1:0]     pos;
  logic              done;
  status_t           st_c;
  logic [QW-1:0]     n_nxt;
  logic              ram_we;
  logic              set_u;
  logic              clr_u;
  logic              at_end;
  flags_t            sel;
  logic              cfg_wr;
  logic [LEN_W-1:0]  cfg_mw;
  logic              in_acc;
  logic              in_id_ok;
  logic [AW-1:0]     in_addr;
  logic [RW-1:0]     ram_rdata;

  entry_t            cur   [FREE_SLOTS];
  entry_t            post  [FREE_SLOTS];
  flags_t            flags [FREE_SLOTS];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign cfg_mw = (32'(pwdata[LEN_W-1:0]) > 32'(MEM_WORDS)) ? MW_RST : pwdata[LEN_W-1:0];
  assign prdata = paddr[2] ? 32'd0 : 32'(mw_r);

  // Input side.
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_id_ok = 32'(in_seg_id) < 32'(SEG_IDS);
  assign in_addr  = AW'(in_seg_id);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_free_ranges = out_free_r;

  // Segment base and length store.
  sra_ram #(.WIDTH(RW), .DEPTH(SEG_IDS)) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_addr_r),
    .wdata ({bbase_r, blen_r}),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Row of free table cells.
  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    entry_t lc;
    entry_t lp;
    entry_t rc;
    if (g == 0) begin : g_first
      assign lc = '0;
      assign lp = '0;
    end else begin : g_mid
      assign lc = cur[g-1];
      assign lp = post[g-1];
    end
    if (g == FREE_SLOTS - 1) begin : g_last
      assign rc = '0;
    end else begin : g_body
      assign rc = cur[g+1];
    end
    sra_cell #(.QW(QW), .IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .pos       (pos),
      .left_cur  (lc),
      .left_post (lp),
      .right_cur (rc),
      .cur       (cur[g]),
      .post      (post[g]),
      .flags     (flags[g])
    );
  end

  // Scan decision and command to the cell row.
  assign at_end = (k_r == n_r);
  assign sel    = at_end ? flags_t'('0) : flags[k_r[IW-1:0]];

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.base = bbase_r;
    cmd.len  = blen_r;
    pos      = k_r;
    done     = 1'b0;
    st_c     = ST_OK;
    n_nxt    = n_r;
    ram_we   = 1'b0;
    set_u    = 1'b0;
    clr_u    = 1'b0;
    if (state_r == S_INIT) begin
      cmd.op  = OP_INIT;
      cmd.len = mw_r;
      n_nxt   = QW'(mw_r != '0);
    end else if (cfg_wr) begin
      cmd.op  = OP_INIT;
      cmd.len = cfg_mw;
      n_nxt   = QW'(cfg_mw != '0);
    end else if (state_r == S_SCAN) begin
      if (func_r == FUNC_CREATE) begin
        // Create: first free range that covers the request.
        if (at_end) begin
          done = 1'b1;
          st_c = ST_NOFIT;
        end else if (sel.hit) begin
          done = 1'b1;
          if (!id_ok_r) begin
            st_c = ST_UNKNOWN;
          end else if (aused_r[id_addr_r]) begin
            st_c = ST_INUSE;
          end else if (sel.has_pre && sel.has_post && (n_r == FULL)) begin
            st_c = ST_NOFIT;
          end else begin
            ram_we = 1'b1;
            set_u  = 1'b1;
            if (sel.has_pre && sel.has_post) begin
              cmd.op = OP_SPLIT2;
              n_nxt  = n_r + QW'(1);
            end else if (sel.has_pre) begin
              cmd.op = OP_PRE;
            end else if (sel.has_post) begin
              cmd.op = OP_POST;
            end else begin
              cmd.op = OP_DEL;
              n_nxt  = n_r - QW'(1);
            end
          end
        end
      end else begin
        // Remove: insertion place, then merge with touching neighbors.
        if (at_end || sel.gt) begin
          done = 1'b1;
          if (prev_tl_r && sel.touch_r) begin
            cmd.op = OP_MERGE3;
            pos    = k_r - QW'(1);
            n_nxt  = n_r - QW'(1);
            clr_u  = 1'b1;
          end else if (prev_tl_r) begin
            cmd.op = OP_GROW_L;
            pos    = k_r - QW'(1);
            clr_u  = 1'b1;
          end else if (sel.touch_r) begin
            cmd.op = OP_GROW_R;
            clr_u  = 1'b1;
          end else if (n_r == FULL) begin
            st_c = ST_NOFIT;
          end else begin
            cmd.op = OP_INS;
            n_nxt  = n_r + QW'(1);
            clr_u  = 1'b1;
          end
        end
      end
    end
  end

  // Control state, request registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      n_r         <= '0;
      mw_r        <= MW_RST;
      aused_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      prev_tl_r   <= 1'b0;
    end else begin
      n_r <= n_nxt;
      // A result leaves here unless the finish step reloads the register.
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        mw_r    <= cfg_mw;
        aused_r <= '0;
      end
      if (set_u) begin
        aused_r[id_addr_r] <= 1'b1;
      end
      if (clr_u) begin
        aused_r[id_addr_r] <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r    <= in_func;
            id_ok_r   <= in_id_ok;
            id_addr_r <= in_addr;
            bbase_r   <= in_seg_start;
            blen_r    <= in_seg_size;
            k_r       <= '0;
            prev_tl_r <= 1'b0;
            if (in_func == FUNC_CREATE) begin
              if (in_seg_size == '0) begin
                st_r    <= ST_BADLEN;
                state_r <= S_FIN;
              end else begin
                state_r <= S_SCAN;
              end
            end else if (!in_id_ok || !aused_r[in_addr]) begin
              st_r    <= ST_UNKNOWN;
              state_r <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          bbase_r <= ram_rdata[RW-1:LEN_W];
          blen_r  <= ram_rdata[LEN_W-1:0];
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (done) begin
            st_r    <= st_c;
            state_r <= S_FIN;
          end else begin
            prev_tl_r <= sel.touch_l;
            k_r       <= k_r + QW'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_free_r   <= 4'(n_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/sra_checker.sv =====
// Checker for the segment range allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module sra_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [2:0]  in_seg_id,
  input  logic [9:0]  in_seg_start,
  input  logic [10:0] in_seg_size,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_free_ranges,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import sra_pkg::*;

  localparam int MEM_WORDS  = 1024;
  localparam int SEG_IDS    = 8;
  localparam int FREE_SLOTS = 9;

  typedef struct {
    status_t    status;
    logic [3:0] free_ranges;
  } outcome_t;

  // Shadow copy of the allocator state.
  int               words;
  logic [BASE_W-1:0] hole_base [FREE_SLOTS];
  logic [LEN_W-1:0]  hole_len  [FREE_SLOTS];
  bit                hole_used [FREE_SLOTS];
  logic [BASE_W-1:0] seg_base  [SEG_IDS];
  logic [LEN_W-1:0]  seg_len   [SEG_IDS];
  bit                seg_used  [SEG_IDS];
  int                new_base  [FREE_SLOTS + 2];
  int                new_len   [FREE_SLOTS + 2];

  outcome_t awaited[$];

  assign pending = awaited.size();

  function automatic int hole_count();
    int n;
    n = 0;
    while (n < FREE_SLOTS && hole_used[n]) n++;
    return n;
  endfunction

  // Empties the segment store and, when memory is not empty, leaves one free range over all of it.
  function automatic void wipe();
    for (int i = 0; i < FREE_SLOTS; i++) begin
      hole_used[i] = 0;
      hole_base[i] = '0;
      hole_len[i]  = '0;
    end
    for (int i = 0; i < SEG_IDS; i++) begin
      seg_used[i] = 0;
      seg_base[i] = '0;
      seg_len[i]  = '0;
    end
    if (words > 0) begin
      hole_used[0] = 1;
      hole_len[0]  = LEN_W'(words);
    end
  endfunction

  // Installs the staged free table when it fits.
  function automatic bit install(int m);
    if (m > FREE_SLOTS) return 0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      hole_used[i] = i < m;
      hole_base[i] = i < m ? BASE_W'(new_base[i]) : '0;
      hole_len[i]  = i < m ? LEN_W'(new_len[i]) : '0;
    end
    return 1;
  endfunction

  function automatic status_t place_segment(int id, int start, int size);
    int n, stop, i, m, top;
    n = hole_count();
    stop = start + size;
    m = 0;
    if (size == 0) return ST_BADLEN;
    for (i = 0; i < n; i++)
      if (hole_base[i] <= start && int'(hole_base[i]) + int'(hole_len[i]) >= stop) break;
    if (i == n) return ST_NOFIT;
    if (seg_used[id]) return ST_INUSE;
    top = int'(hole_base[i]) + int'(hole_len[i]);
    for (int k = 0; k < i; k++) begin
      new_base[m] = hole_base[k];
      new_len[m]  = hole_len[k];
      m++;
    end
    // Keep the pieces before and after the new segment.
    if (hole_base[i] < start) begin
      new_base[m] = hole_base[i];
      new_len[m]  = start - int'(hole_base[i]);
      m++;
    end
    if (top > stop) begin
      new_base[m] = stop;
      new_len[m]  = top - stop;
      m++;
    end
    for (int k = i + 1; k < n; k++) begin
      new_base[m] = hole_base[k];
      new_len[m]  = hole_len[k];
      m++;
    end
    if (!install(m)) return ST_NOFIT;
    seg_base[id] = BASE_W'(start);
    seg_len[id]  = LEN_W'(size);
    seg_used[id] = 1;
    return ST_OK;
  endfunction

  function automatic status_t release_segment(int id);
    int n, m, r;
    bit placed;
    n = hole_count();
    m = 0;
    placed = 0;
    if (!seg_used[id]) return ST_UNKNOWN;
    // Insert the returned range in address order.
    for (int k = 0; k < n; k++) begin
      if (!placed && seg_base[id] < hole_base[k]) begin
        new_base[m] = seg_base[id];
        new_len[m]  = seg_len[id];
        m++;
        placed = 1;
      end
      new_base[m] = hole_base[k];
      new_len[m]  = hole_len[k];
      m++;
    end
    if (!placed) begin
      new_base[m] = seg_base[id];
      new_len[m]  = seg_len[id];
      m++;
    end
    // Coalesce ranges that touch.
    r = 0;
    for (int k = 1; k < m; k++) begin
      if (new_base[r] + new_len[r] == new_base[k]) begin
        new_len[r] += new_len[k];
      end else begin
        r++;
        new_base[r] = new_base[k];
        new_len[r]  = new_len[k];
      end
    end
    if (!install(r + 1)) return ST_NOFIT;
    seg_used[id] = 0;
    seg_base[id] = '0;
    seg_len[id]  = '0;
    return ST_OK;
  endfunction

  // Watch the three ports on every rising edge.
  always @(posedge clk) begin
    outcome_t want, got;
    int v;
    if (!rst_n) begin
      words = MEM_WORDS;
      wipe();
      awaited.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MEMORY_WORDS) begin
        v = int'(pwdata[10:0]);
        words = v > MEM_WORDS ? MEM_WORDS : v;
        wipe();
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_REMOVE)
          want.status = release_segment(in_seg_id);
        else
          want.status = place_segment(in_seg_id, in_seg_start, in_seg_size);
        want.free_ranges = 4'(hole_count());
        awaited.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.status = status_t'(out_status);
        got.free_ranges = out_free_ranges;
        if (awaited.size() == 0) begin
          $error("result item with nothing expected: status %0d free_ranges %0d",
                 out_status, out_free_ranges);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (got.free_ranges !== want.free_ranges) begin
            $error("free_ranges: expected %0d, actual %0d",
                   want.free_ranges, out_free_ranges);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the segment range allocator testbench: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module testbench;
  import sra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PHASE_ITEMS    = 200;
  localparam int LONG_STALL     = 400;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_func = 0;
  logic [2:0]  in_seg_id = '0;
  logic [9:0]  in_seg_start = '0;
  logic [10:0] in_seg_size = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [3:0]  out_free_ranges;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_asked = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int words = 1024;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  segment_range_allocator_core dut (.*);

  sra_checker u_checker (.*);

  // Result side: random back-pressure plus one long hold-off when asked.
  always @(posedge clk) begin
    if (stall_asked != stall_seen) begin
      stall_seen <= stall_asked;
      stall_left <= LONG_STALL;
      out_ready  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("segment_range_allocator_core regression: fail");
        $finish;
      end
    end
  end

  // Offers one item; valid is left to the next item or to drain.
  task automatic send_item(bit func, int id, int start, int size);
    bit took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid     <= 1;
    in_func      <= func;
    in_seg_id    <= 3'(id);
    in_seg_start <= 10'(start);
    in_seg_size  <= 11'(size);
    forever begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
      if (took) break;
    end
    items_sent++;
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int value);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
    cfg_writes++;
    if (addr == ADDR_MEMORY_WORDS) words = value > 1024 ? 1024 : value;
  endtask

  // Mostly in-range requests with small sizes, plus raw noise on every field.
  task automatic send_random_item();
    bit func;
    int start, size, cap;
    func = $urandom_range(0, 99) < 40;
    cap = words > 8 ? words / 6 : 1;
    if ($urandom_range(0, 99) < 85 && words > 0)
      start = $urandom_range(0, words - 1);
    else
      start = $urandom_range(0, 1023);
    case ($urandom_range(0, 19))
      0: size = 0;
      1, 2: size = $urandom_range(0, 2047);
      default: size = $urandom_range(1, cap);
    endcase
    send_item(func, $urandom_range(0, 7), start, size);
  endtask

  initial begin
    int mem_sizes [6] = '{16, 0, 1, 2047, 100, 1024};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: boundaries, coalescing and every status code.
    send_item(FUNC_CREATE, 0, 0, 0);
    send_item(FUNC_CREATE, 0, 0, 1024);
    send_item(FUNC_CREATE, 1, 0, 1);
    send_item(FUNC_REMOVE, 0, 0, 0);
    send_item(FUNC_REMOVE, 0, 0, 0);
    send_item(FUNC_CREATE, 0, 1023, 1);
    send_item(FUNC_CREATE, 0, 0, 1);
    send_item(FUNC_CREATE, 1, 1023, 2047);
    send_item(FUNC_CREATE, 7, 100, 10);
    send_item(FUNC_CREATE, 3, 110, 5);
    send_item(FUNC_CREATE, 4, 95, 5);
    send_item(FUNC_REMOVE, 7, 0, 0);
    send_item(FUNC_REMOVE, 3, 0, 0);
    send_item(FUNC_REMOVE, 4, 0, 0);
    send_item(FUNC_CREATE, 5, 512, 512);
    send_item(FUNC_CREATE, 6, 511, 1);
    send_item(FUNC_REMOVE, 0, 0, 0);
    send_item(FUNC_REMOVE, 5, 0, 0);
    send_item(FUNC_REMOVE, 6, 0, 0);
    send_item(FUNC_REMOVE, 2, 1023, 2047);
    drain();
    write_reg(ADDR_UNMAPPED, 5);

    // Random phases over several memory sizes and idling patterns.
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(ADDR_MEMORY_WORDS, mem_sizes[p]);
      send_idle_pct = p < 2 ? 17 : (p < 4 ? 56 : 0);
      recv_idle_pct = p < 2 ? 56 : (p < 4 ? 17 : 0);
      for (int i = 0; i < PHASE_ITEMS + (p == 5 ? 300 : 0); i++) begin
        if (p == 5 && i == 40) stall_asked <= stall_asked + 1;
        send_random_item();
      end
    end
    drain();

    $display("Ran %0d request items and %0d register writes across six memory sizes,",
             items_sent, cfg_writes);
    $display("with idling on either side, none, and one long result-side stall.");
    if (errors == 0) begin
      $display("segment_range_allocator_core regression: pass");
    end else begin
      $display("segment_range_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
